// File: rtl/rdsge_pkg.sv
// shared types, constants and check-word logic for the rds group encoder
package rdsge_pkg;

    localparam int RT_CHARS_DEF = 64;
    localparam int GROUP_BITS   = 104;

    localparam logic [9:0]  OFS_A     = 10'h0FC;
    localparam logic [9:0]  OFS_B     = 10'h198;
    localparam logic [9:0]  OFS_C     = 10'h168;
    localparam logic [9:0]  OFS_D     = 10'h1B4;
    localparam logic [15:0] FILL_WORD = 16'hCDCD;

    // configuration register indexes
    localparam logic [2:0] REG_PI  = 3'd0;
    localparam logic [2:0] REG_PTY = 3'd1;
    localparam logic [2:0] REG_TP  = 3'd2;
    localparam logic [2:0] REG_TA  = 3'd3;
    localparam logic [2:0] REG_MS  = 3'd4;
    localparam logic [2:0] REG_AF1 = 3'd5;
    localparam logic [2:0] REG_AF2 = 3'd6;
    localparam logic [2:0] REG_PS  = 3'd7;

    typedef enum logic [1:0] {
        KIND_PS = 2'd0,
        KIND_RT = 2'd1,
        KIND_AF = 2'd2,
        KIND_CT = 2'd3
    } t_kind;

    typedef struct packed {
        logic [15:0] pi;
        logic [4:0]  pty;
        logic        tp;
        logic        ta;
        logic        ms;
        logic [7:0]  af1;
        logic [7:0]  af2;
        logic [63:0] ps;
    } t_cfg;

    typedef struct packed {
        logic [16:0] mjd;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  offset;
    } t_clock;

    // check word of a single data bit, data bit 0 first
    function automatic logic [9:0] crc_col(input logic [3:0] j);
        logic [9:0] v;
        case (j)
            4'd0:    v = 10'h1B9;
            4'd1:    v = 10'h372;
            4'd2:    v = 10'h35D;
            4'd3:    v = 10'h303;
            4'd4:    v = 10'h3BF;
            4'd5:    v = 10'h2C7;
            4'd6:    v = 10'h037;
            4'd7:    v = 10'h06E;
            4'd8:    v = 10'h0DC;
            4'd9:    v = 10'h1B8;
            4'd10:   v = 10'h370;
            4'd11:   v = 10'h359;
            4'd12:   v = 10'h30B;
            4'd13:   v = 10'h3AF;
            4'd14:   v = 10'h2E7;
            4'd15:   v = 10'h077;
            default: v = 10'h000;
        endcase
        return v;
    endfunction

    // linear code, so the check word is the xor of the columns of set bits
    function automatic logic [9:0] crc10(input logic [15:0] d);
        logic [9:0] c;
        c = '0;
        for (int j = 0; j < 16; j++) begin
            if (d[j]) begin
                c = c ^ crc_col(4'(j));
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/rdsge_rt_store.sv
// radiotext character store, four byte banks indexed by segment
module rdsge_rt_store #(
    parameter int RT_CHARS = rdsge_pkg::RT_CHARS_DEF,
    parameter int SEG_W    = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [5:0]       i_wr_index,
    input  logic [7:0]       i_wr_char,
    input  logic [SEG_W-1:0] i_rd_seg,
    output logic [31:0]      o_rd_chars
);
    import rdsge_pkg::*;

    localparam int         RT_SEGS = (RT_CHARS + 3) / 4;
    localparam logic [6:0] LIMIT   = 7'(RT_CHARS);

    logic [7:0]       r_bank [4][RT_SEGS];
    logic             wr_ok;
    logic [SEG_W-1:0] wr_row;

    assign wr_ok  = i_wr_en && ({1'b0, i_wr_index} < LIMIT);
    assign wr_row = i_wr_index[2 +: SEG_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < 4; b++) begin
                for (int r = 0; r < RT_SEGS; r++) begin
                    r_bank[b][r] <= '0;
                end
            end
        end else if (wr_ok) begin
            r_bank[i_wr_index[1:0]][wr_row] <= i_wr_char;
        end
    end

    // positions past the text length are never written and read as zero
    assign o_rd_chars = {r_bank[0][i_rd_seg], r_bank[1][i_rd_seg],
                         r_bank[2][i_rd_seg], r_bank[3][i_rd_seg]};

endmodule

// File: rtl/rdsge_group_build.sv
// assembles the four blocks of one group and appends check words
module rdsge_group_build (
    input  rdsge_pkg::t_cfg   i_cfg,
    input  rdsge_pkg::t_clock i_clock,
    input  logic              i_is_ct,
    input  logic [3:0]        i_cycle_step,
    input  logic [3:0]        i_rt_seg,
    input  logic [31:0]       i_rt_chars,
    output logic [103:0]      o_group,
    output rdsge_pkg::t_kind  o_kind
);
    import rdsge_pkg::*;

    logic [15:0] blk_a, blk_b, blk_c, blk_d;
    logic [1:0]  ps_seg;
    logic [15:0] ps_word;
    logic [15:0] b_0a;
    logic        neg;
    logic [5:0]  mag6;
    logic [4:0]  mag;

    assign ps_seg = i_cycle_step[2:1];
    assign neg    = i_clock.offset[5];
    assign mag6   = neg ? (6'd0 - i_clock.offset) : i_clock.offset;
    assign mag    = mag6[5] ? 5'd31 : mag6[4:0];

    always_comb begin
        case (ps_seg)
            2'd0:    ps_word = i_cfg.ps[63:48];
            2'd1:    ps_word = i_cfg.ps[47:32];
            2'd2:    ps_word = i_cfg.ps[31:16];
            2'd3:    ps_word = i_cfg.ps[15:0];
            default: ps_word = i_cfg.ps[63:48];
        endcase
    end

    always_comb begin
        blk_a = i_cfg.pi;
        b_0a  = {5'd0, i_cfg.tp, i_cfg.pty, i_cfg.ta, i_cfg.ms, 3'd0};
        if (i_is_ct) begin
            blk_b  = {1'b0, 1'b1, 3'd0, i_cfg.tp, 8'd0, i_clock.mjd[16:15]};
            blk_c  = {i_clock.mjd[14:0], i_clock.hour[4]};
            blk_d  = {i_clock.hour[3:0], i_clock.minute, neg, mag};
            o_kind = KIND_CT;
        end else if (i_cycle_step < 4'd8) begin
            blk_b  = b_0a | {13'd0, ps_seg == 2'd3, ps_seg};
            blk_c  = FILL_WORD;
            blk_d  = ps_word;
            o_kind = KIND_PS;
        end else if (i_cycle_step == 4'd8) begin
            blk_b  = {3'b001, 3'd0, i_cfg.pty, i_cfg.ta, i_rt_seg};
            blk_c  = i_rt_chars[31:16];
            blk_d  = i_rt_chars[15:0];
            o_kind = KIND_RT;
        end else begin
            blk_b = b_0a;
            if (i_cfg.af1 != 8'd0 && i_cfg.af2 != 8'd0) begin
                blk_c = {i_cfg.af1, i_cfg.af2};
            end else if (i_cfg.af1 != 8'd0) begin
                blk_c = {i_cfg.af1, i_cfg.af1};
            end else begin
                blk_c = FILL_WORD;
            end
            blk_d  = i_cfg.ps[63:48];
            o_kind = KIND_AF;
        end
    end

    assign o_group = {blk_a, crc10(blk_a) ^ OFS_A,
                      blk_b, crc10(blk_b) ^ OFS_B,
                      blk_c, crc10(blk_c) ^ OFS_C,
                      blk_d, crc10(blk_d) ^ OFS_D};

endmodule

// File: rtl/rds_group_bitstream_encoder.sv
// top level of the rds group bitstream encoder
// Usage:
// - input channel (i_valid/o_ready) carries one word per rds bit period:
//   a tick (operation 0) or a radiotext character write (operation 1)
// - each tick gives one output word (o_valid/i_ready): the raw group bit,
//   the differentially coded line bit, its index in the 104-bit group, the
//   group kind and a last-of-group flag; a write gives no output word
// - the output word of a tick is registered and shows in the cycle after
//   acceptance; while the receiver is ready a new word can be accepted
//   every cycle, the group assembly and check words being a single pass
//   of logic between the tick register state and the output register
// - a group is built on the tick that follows the last bit of the
//   previous one, using the clock fields of that tick
// - configuration is written through i_cfg_we/i_cfg_index/i_cfg_data at
//   any edge, intended while the block is idle
// - reset (synchronous, active low) restores the register defaults,
//   clears the text store and forces a clock-time group on the first tick
// - while the receiver stalls the output word holds and o_ready drops, so
//   nothing is accepted until the pending word is taken
module rds_group_bitstream_encoder #(
    parameter int RT_CHARS = rdsge_pkg::RT_CHARS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_operation,
    input  logic [5:0]  i_rt_index,
    input  logic [7:0]  i_rt_char,
    input  logic [16:0] i_day_number,
    input  logic [4:0]  i_utc_hour,
    input  logic [5:0]  i_utc_minute,
    input  logic signed [5:0] i_local_offset,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_data_bit,
    output logic        o_line_bit,
    output logic [6:0]  o_bit_index,
    output logic [1:0]  o_group_kind,
    output logic        o_last_of_group
);
    import rdsge_pkg::*;

    localparam int RT_SEGS = (RT_CHARS + 3) / 4;
    localparam int SEG_W   = (RT_SEGS > 1) ? $clog2(RT_SEGS) : 1;
    localparam logic [SEG_W:0] SEG_END  = (SEG_W + 1)'(RT_SEGS);
    localparam logic [6:0]     LAST_BIT = 7'(GROUP_BITS - 1);
    localparam logic [6:0]     NO_GROUP = 7'(GROUP_BITS);

    t_cfg             r_cfg;
    logic [6:0]       r_bit_pos;
    logic [103:0]     r_shift;
    t_kind            r_kind;
    logic             r_line;
    logic [6:0]       r_last_min;
    logic [3:0]       r_cycle;
    logic [SEG_W-1:0] r_rt_seg;

    logic             r_out_valid;
    logic             r_data_bit;
    logic             r_line_bit;
    logic [6:0]       r_bit_index;
    t_kind            r_out_kind;
    logic             r_last;

    logic             accept, tick, rt_write, new_grp, is_ct;
    logic [31:0]      rt_chars;
    logic [103:0]     built, n_shift;
    t_kind            built_kind, n_kind;
    logic [6:0]       pos;
    logic             bit_now;
    logic [3:0]       n_cycle;
    logic [SEG_W:0]   seg_inc;
    logic [SEG_W-1:0] n_rt_seg;
    t_clock           clk_fields;

    assign o_ready  = !r_out_valid || i_ready;
    assign accept   = i_valid && o_ready;
    assign tick     = accept && !i_operation;
    assign rt_write = accept && i_operation;

    assign clk_fields = '{mjd: i_day_number, hour: i_utc_hour,
                          minute: i_utc_minute, offset: i_local_offset};

    assign new_grp = r_bit_pos >= NO_GROUP;
    assign is_ct   = {1'b0, i_utc_minute} != r_last_min;

    rdsge_rt_store #(
        .RT_CHARS (RT_CHARS),
        .SEG_W    (SEG_W)
    ) u_rt_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (rt_write),
        .i_wr_index (i_rt_index),
        .i_wr_char  (i_rt_char),
        .i_rd_seg   (r_rt_seg),
        .o_rd_chars (rt_chars)
    );

    rdsge_group_build u_group_build (
        .i_cfg        (r_cfg),
        .i_clock      (clk_fields),
        .i_is_ct      (is_ct),
        .i_cycle_step (r_cycle),
        .i_rt_seg     (4'(r_rt_seg)),
        .i_rt_chars   (rt_chars),
        .o_group      (built),
        .o_kind       (built_kind)
    );

    always_comb begin
        n_shift  = new_grp ? built : r_shift;
        n_kind   = new_grp ? built_kind : r_kind;
        pos      = new_grp ? 7'd0 : r_bit_pos;
        bit_now  = n_shift[103];
        n_cycle  = (r_cycle >= 4'd9) ? 4'd0 : r_cycle + 4'd1;
        seg_inc  = {1'b0, r_rt_seg} + 1'b1;
        n_rt_seg = (seg_inc >= SEG_END) ? '0 : seg_inc[SEG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= '{pi: '0, pty: '0, tp: 1'b0, ta: 1'b0, ms: 1'b1,
                             af1: '0, af2: '0, ps: '0};
            r_bit_pos   <= NO_GROUP;
            r_kind      <= KIND_PS;
            r_line      <= 1'b0;
            r_last_min  <= 7'h7F;
            r_cycle     <= '0;
            r_rt_seg    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_PI:  r_cfg.pi  <= i_cfg_data[15:0];
                    REG_PTY: r_cfg.pty <= i_cfg_data[4:0];
                    REG_TP:  r_cfg.tp  <= i_cfg_data[0];
                    REG_TA:  r_cfg.ta  <= i_cfg_data[0];
                    REG_MS:  r_cfg.ms  <= i_cfg_data[0];
                    REG_AF1: r_cfg.af1 <= i_cfg_data[7:0];
                    REG_AF2: r_cfg.af2 <= i_cfg_data[7:0];
                    REG_PS:  r_cfg.ps  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (tick) begin
                r_bit_pos <= pos + 7'd1;
                r_kind    <= n_kind;
                r_line    <= r_line ^ bit_now;
                if (new_grp) begin
                    if (is_ct) begin
                        r_last_min <= {1'b0, i_utc_minute};
                    end else begin
                        // clock-time groups leave the cycle where it was
                        r_cycle <= n_cycle;
                        if (r_cycle == 4'd8) begin
                            r_rt_seg <= n_rt_seg;
                        end
                    end
                end
            end
            if (tick) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (tick) begin
            r_shift     <= {n_shift[102:0], 1'b0};
            r_data_bit  <= bit_now;
            r_line_bit  <= r_line ^ bit_now;
            r_bit_index <= pos;
            r_out_kind  <= n_kind;
            r_last      <= pos == LAST_BIT;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_data_bit      = r_data_bit;
    assign o_line_bit      = r_line_bit;
    assign o_bit_index     = r_bit_index;
    assign o_group_kind    = r_out_kind;
    assign o_last_of_group = r_last;

endmodule
